// File: hw/rtl/dmm_pkg.sv
// Shared types and constants for the duration min/max/mean monitor.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dmm_pkg;

  localparam int unsigned TimeBitsDefault  = 48;
  localparam int unsigned CountBitsDefault = 32;

  localparam int unsigned TimeW     = 48;
  localparam int unsigned CountW    = 32;
  localparam int unsigned InDataW   = 2 * TimeW;
  localparam int unsigned OutDataW  = 3 * TimeW + CountW;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    KIND_RECORD = 1'b0,
    KIND_CLEAR  = 1'b1
  } kind_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/dmm_queue.sv
// Small request queue between the front and the back of the monitor.
// Depends on dmm_pkg for the depth and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module dmm_queue #(
  parameter int unsigned WIDTH = 49
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire logic [WIDTH-1:0]      push_data_i,
  input  wire logic                  pop_i,
  output logic [WIDTH-1:0]           pop_data_o,
  output dmm_pkg::q_status_t         status_o
);

  localparam int unsigned Depth = dmm_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [WIDTH-1:0] entries_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic             do_push, do_pop;

  assign status_o.full  = (fill_q == CntW'(Depth));
  assign status_o.empty = (fill_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign pop_data_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dmm_front.sv
// Front end of the monitor: takes input requests, forms the wrapped duration
// and classifies each request as record or clear. Depends on dmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmm_front #(
  parameter int unsigned TIME_BITS = dmm_pkg::TimeBitsDefault
) (
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [dmm_pkg::InDataW-1:0]   s_axis_tdata_i,
  input  wire logic [0:0]                    s_axis_tuser_i,
  input  wire dmm_pkg::q_status_t            q_status_i,
  output logic                               push_o,
  output logic [TIME_BITS:0]                 push_data_o
);

  logic [TIME_BITS-1:0] start_t;
  logic [TIME_BITS-1:0] end_t;
  logic [TIME_BITS-1:0] duration;
  dmm_pkg::kind_e       kind;

  assign start_t  = TIME_BITS'(s_axis_tdata_i[dmm_pkg::TimeW-1:0]);
  assign end_t    = TIME_BITS'(s_axis_tdata_i[dmm_pkg::InDataW-1:dmm_pkg::TimeW]);
  assign duration = end_t - start_t;
  assign kind     = dmm_pkg::kind_e'(s_axis_tuser_i[0]);

  assign s_axis_tready_o = !q_status_i.full;
  assign push_o          = s_axis_tvalid_i && !q_status_i.full;
  assign push_data_o     = {kind, duration};

endmodule

`default_nettype wire

// File: hw/rtl/dmm_back.sv
// Back end of the monitor: keeps the statistics, runs a bit-serial divider
// for the mean update and holds the result register. Depends on dmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmm_back #(
  parameter int unsigned TIME_BITS  = dmm_pkg::TimeBitsDefault,
  parameter int unsigned COUNT_BITS = dmm_pkg::CountBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dmm_pkg::q_status_t            q_status_i,
  input  wire logic [TIME_BITS:0]            q_data_i,
  output logic                               pop_o,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [dmm_pkg::OutDataW-1:0]       m_axis_tdata_o
);

  localparam int unsigned BitW = $clog2(TIME_BITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [TIME_BITS-1:0]        min_q, min_d;
  logic [TIME_BITS-1:0]        max_q, max_d;
  logic [TIME_BITS-1:0]        mean_q, mean_d;
  logic [COUNT_BITS-1:0]       count_q, count_d;
  logic                        rec_q, rec_d;
  logic                        neg_q, neg_d;
  logic [TIME_BITS-1:0]        quo_q, quo_d;
  logic [COUNT_BITS:0]         rem_q, rem_d;
  logic [BitW-1:0]             bit_q, bit_d;
  logic                        out_valid_q, out_valid_d;
  logic [dmm_pkg::OutDataW-1:0] out_data_q, out_data_d;

  dmm_pkg::kind_e              kind;
  logic [TIME_BITS-1:0]        dur;
  logic [COUNT_BITS:0]         rem_shift;
  logic                        rem_ge;
  logic [TIME_BITS-1:0]        mean_step;
  logic [TIME_BITS-1:0]        mean_new;
  logic                        out_free;

  assign kind      = dmm_pkg::kind_e'(q_data_i[TIME_BITS]);
  assign dur       = q_data_i[TIME_BITS-1:0];
  assign rem_shift = {rem_q[COUNT_BITS-1:0], quo_q[TIME_BITS-1]};
  assign rem_ge    = (rem_shift >= {1'b0, count_q});
  assign mean_step = quo_q + TIME_BITS'(neg_q && (rem_q != '0));
  assign mean_new  = rec_q ? (neg_q ? mean_q - mean_step : mean_q + mean_step) : mean_q;
  assign out_free  = !out_valid_q || m_axis_tready_i;

  assign pop_o           = (state_q == ST_IDLE) && !q_status_i.empty;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_comb begin
    state_d     = state_q;
    min_d       = min_q;
    max_d       = max_q;
    mean_d      = mean_q;
    count_d     = count_q;
    rec_d       = rec_q;
    neg_d       = neg_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          unique case (kind)
            dmm_pkg::KIND_CLEAR: begin
              min_d   = '1;
              max_d   = '0;
              mean_d  = '0;
              count_d = '0;
              rec_d   = 1'b0;
              state_d = ST_FIN;
            end
            dmm_pkg::KIND_RECORD: begin
              if (dur < min_q) begin
                min_d = dur;
              end
              if (dur > max_q) begin
                max_d = dur;
              end
              if (count_q != '1) begin
                count_d = count_q + COUNT_BITS'(1);
              end
              rec_d   = 1'b1;
              neg_d   = (dur < mean_q);
              quo_d   = (dur < mean_q) ? mean_q - dur : dur - mean_q;
              rem_d   = '0;
              bit_d   = BitW'(TIME_BITS - 1);
              state_d = ST_DIV;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_DIV: begin
        rem_d = rem_ge ? rem_shift - {1'b0, count_q} : rem_shift;
        quo_d = {quo_q[TIME_BITS-2:0], rem_ge};
        bit_d = bit_q - BitW'(1);
        if (bit_q == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          mean_d      = mean_new;
          out_valid_d = 1'b1;
          out_data_d  = {dmm_pkg::CountW'(count_q), dmm_pkg::TimeW'(mean_new),
                         dmm_pkg::TimeW'(max_q), dmm_pkg::TimeW'(min_q)};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      min_q       <= '1;
      max_q       <= '0;
      mean_q      <= '0;
      count_q     <= '0;
      rec_q       <= 1'b0;
      neg_q       <= 1'b0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      min_q       <= min_d;
      max_q       <= max_d;
      mean_q      <= mean_d;
      count_q     <= count_d;
      rec_q       <= rec_d;
      neg_q       <= neg_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    out_data_q <= out_data_d;
  end

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (min_q <= max_q))
    else $error("Minimum exceeds maximum while samples are held.");

  a_mean_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && count_q != '0) |-> (mean_q >= min_q && mean_q <= max_q))
    else $error("Mean lies outside the minimum to maximum range.");

  a_empty_stats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (max_q == '0 && mean_q == '0))
    else $error("Statistics are not clear while no sample is held.");

  a_pop_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !q_status_i.empty) |=> (state_q != ST_IDLE))
    else $error("A queued request was taken without starting work.");

endmodule

`default_nettype wire

// File: hw/rtl/duration_min_max_mean_monitor.sv
// Flow: an accepted request enters the queue and the back end pops it when idle.
// A record then runs the bit-serial mean divider, which retires one quotient bit per
// cycle. For either kind the back end waits in the finish state until the output is
// free and loads the result register before it pops the next request. A two-entry queue
// takes requests while the divider works. Reset (rst_ni low, asynchronous) clears the
// statistics: minimum all ones, maximum, mean and count zero; queue and output emptied.
`timescale 1ns / 1ps
`default_nettype none

module duration_min_max_mean_monitor #(
  parameter int unsigned TIME_BITS  = dmm_pkg::TimeBitsDefault,
  parameter int unsigned COUNT_BITS = dmm_pkg::CountBitsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // start_time [47:0], end_time [95:48]
  input  wire logic [dmm_pkg::InDataW-1:0]   s_axis_tdata_i,
  // op [0]
  input  wire logic [0:0]                    s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // shortest [47:0], longest [95:48], mean [143:96], sample_count [175:144]
  output logic [dmm_pkg::OutDataW-1:0]       m_axis_tdata_o
);

  dmm_pkg::q_status_t   q_status;
  logic                 push;
  logic [TIME_BITS:0]   push_data;
  logic                 pop;
  logic [TIME_BITS:0]   pop_data;

  dmm_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_status_i      (q_status),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  dmm_queue #(
    .WIDTH (TIME_BITS + 1)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  dmm_back #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_status_i      (q_status),
    .q_data_i        (pop_data),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire
